>>> rtl/fpau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_pkg: shared types and table math for the fixed-point activation unit
// Mode codes, result widths and the elaboration-time functions that build
// the sigmoid / tanh lookup contents in Q62 integer arithmetic.
// ----------------------------------------------------------------------------
package fpau_pkg;

    // activation function select
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RELU    = 2'd1,
        ACT_SIGMOID = 2'd2,
        ACT_TANH    = 2'd3
    } act_mode_t;

    // lookup word: sigmoid in the upper bits, signed tanh in the lower bits
    localparam int SIG_W  = 10;
    localparam int TANH_W = 11;
    localparam int ROM_W  = SIG_W + TANH_W;

    // saturation values outside the table
    localparam logic [SIG_W-1:0]  SIG_MAX   = 10'd1023;
    localparam logic [TANH_W-1:0] TANH_MAX  = 11'd1023;
    localparam logic [TANH_W-1:0] TANH_LOW  = 11'h401;

    // q62 unit value
    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

    // (a * b) >> 62 for a, b <= 1.0
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // exp(-k/1024) in q62 for k below 2^20
    function automatic logic [63:0] q62_exp_neg(input logic [19:0] k);
        logic [63:0] term;
        logic [63:0] base;
        logic [63:0] acc;
        term = Q62_ONE;
        base = Q62_ONE;
        acc  = Q62_ONE;
        // truncated series for exp(-1/1024)
        term = (term >> 10);
        base = base - term;
        term = (term >> 10) / 2;
        base = base + term;
        term = (term >> 10) / 3;
        base = base - term;
        term = (term >> 10) / 4;
        base = base + term;
        term = (term >> 10) / 5;
        base = base - term;
        term = (term >> 10) / 6;
        base = base + term;
        term = (term >> 10) / 7;
        base = base - term;
        term = (term >> 10) / 8;
        base = base + term;
        // square and multiply over the bits of k
        for (int i = 0; i < 20; i++) begin
            if (k[i]) begin
                acc = q62_mul(acc, base);
            end
            base = q62_mul(base, base);
        end
        return acc;
    endfunction

    // floor(1024 * num / den) by restoring steps, capped at 1023
    function automatic logic [SIG_W-1:0] scaled_div(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [SIG_W:0] q;
        logic [64:0]    r;
        q = '0;
        r = {1'b0, num};
        for (int i = 0; i < 10; i++) begin
            q = {q[SIG_W-1:0], 1'b0};
            r = {r[63:0], 1'b0};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return (q > 11'd1023) ? SIG_MAX : q[SIG_W-1:0];
    endfunction

    // one lookup word for table index idx of a table with entries words
    function automatic logic [ROM_W-1:0] table_word(input int idx, input int entries);
        int                x;
        logic [19:0]       mag;
        logic              neg;
        logic [63:0]       e;
        logic [SIG_W-1:0]  sig;
        logic [SIG_W-1:0]  q;
        logic [TANH_W-1:0] th;
        x   = idx - (entries >>> 1);
        neg = (x < 0);
        mag = neg ? 20'(-x) : 20'(x);
        // sigmoid
        e   = q62_exp_neg(mag);
        sig = neg ? scaled_div(e, Q62_ONE + e) : scaled_div(Q62_ONE, Q62_ONE + e);
        // tanh, truncated toward zero
        e   = q62_exp_neg({mag[18:0], 1'b0});
        q   = scaled_div(Q62_ONE - e, Q62_ONE + e);
        th  = neg ? (TANH_W'(0) - {1'b0, q}) : {1'b0, q};
        return {sig, th};
    endfunction

endpackage

>>> rtl/fpau_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_in_if: sample input channel
// Valid/ready channel carrying one signed fixed-point sample per transfer.
// ----------------------------------------------------------------------------
interface fpau_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/fpau_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_out_if: activated sample output channel
// Valid/ready channel carrying one activated fixed-point sample per transfer.
// ----------------------------------------------------------------------------
interface fpau_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/fixed_point_activation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_activation_unit: sigmoid / tanh / relu on Q.10 samples
// Applies the configured activation to a stream of fixed-point samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : valid/ready sink, one signed sample (scale 1024) per transfer
//   out_chan : valid/ready source, one activated sample per transfer
//   cfg_wr_en / cfg_wr_data : writes act_mode (0 none, 1 relu, 2 sigmoid,
//   3 tanh); change it only while no sample is in flight
// A sample is registered in the lookup stage, then in the output register.
//   Throughput: one sample per cycle, sustained while out_chan is ready.
// Sigmoid and tanh come from one lookup ROM of TABLE_ENTRIES 21-bit words,
//   built at elaboration and read once per sample through a registered
//   port; that single read port sets the rate of one sample per cycle.
//   Samples outside the table saturate without using the read data.
// Reset clears act_mode to pass-through and empties both pipeline stages.
// When out_chan stalls, the result holds in the output register and one
//   more sample is still taken into the lookup stage; after that in_chan
//   drops ready until the output moves.
// ----------------------------------------------------------------------------
module fixed_point_activation_unit #(
    parameter int DATA_WIDTH    = 32,
    parameter int TABLE_ENTRIES = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    fpau_in_if.sink             in_chan,
    fpau_out_if.source          out_chan
);
    import fpau_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CMP_W  = ((DATA_WIDTH > ADDR_W + 1) ? DATA_WIDTH : ADDR_W + 1) + 1;
    localparam logic signed [CMP_W-1:0] HALF_S     = CMP_W'(TABLE_ENTRIES / 2);
    localparam logic signed [CMP_W-1:0] NEG_HALF_S = -HALF_S;

    // configuration
    act_mode_t act_mode_reg;

    // lookup stage
    logic                  s1_valid_reg;
    act_mode_t             s1_mode_reg;
    logic                  s1_below_reg;
    logic                  s1_above_reg;
    logic [DATA_WIDTH-1:0] s1_sample_reg;
    logic [ROM_W-1:0]      rom_q_reg;

    // output stage
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;

    logic                    in_accept;
    logic                    advance_out;
    logic signed [CMP_W-1:0] x_ext;
    logic signed [CMP_W-1:0] idx_full;
    logic                    below;
    logic                    above;
    logic [ADDR_W-1:0]       rom_addr;
    logic [SIG_W-1:0]        sig_val;
    logic [TANH_W-1:0]       tanh_val;
    logic [DATA_WIDTH-1:0]   result_next;

    // lookup rom contents, one constant word per entry
    logic [ROM_W-1:0] rom_mem [TABLE_ENTRIES];

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [ROM_W-1:0] WORD = table_word(gi, TABLE_ENTRIES);
        assign rom_mem[gi] = WORD;
    end

    // handshake
    assign advance_out    = !out_valid_reg || out_chan.ready;
    assign in_chan.ready  = !s1_valid_reg || advance_out;
    assign in_accept      = in_chan.valid && in_chan.ready;
    assign out_chan.valid = out_valid_reg;
    assign out_chan.sample_out = out_data_reg;

    // range check and table address
    always_comb
    begin
        x_ext    = {{(CMP_W - DATA_WIDTH){in_chan.sample_in[DATA_WIDTH-1]}},
                    in_chan.sample_in};
        below    = (x_ext < NEG_HALF_S);
        above    = (x_ext >= HALF_S);
        idx_full = x_ext + HALF_S;
        rom_addr = (below || above) ? '0 : idx_full[ADDR_W-1:0];
    end

    // registered rom read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rom_q_reg <= rom_mem[rom_addr];
        end
    end

    // lookup stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg   <= act_mode_reg;
            s1_below_reg  <= below;
            s1_above_reg  <= above;
            s1_sample_reg <= in_chan.sample_in;
        end
    end

    // result select
    always_comb
    begin
        sig_val  = rom_q_reg[ROM_W-1:TANH_W];
        tanh_val = rom_q_reg[TANH_W-1:0];
        unique case (s1_mode_reg)
            ACT_NONE:
            begin
                result_next = s1_sample_reg;
            end
            ACT_RELU:
            begin
                result_next = s1_sample_reg[DATA_WIDTH-1] ? '0 : s1_sample_reg;
            end
            ACT_SIGMOID:
            begin
                priority if (s1_below_reg)
                    result_next = '0;
                else if (s1_above_reg)
                    result_next = {{(DATA_WIDTH - SIG_W){1'b0}}, SIG_MAX};
                else
                    result_next = {{(DATA_WIDTH - SIG_W){1'b0}}, sig_val};
            end
            ACT_TANH:
            begin
                priority if (s1_below_reg)
                    result_next = {{(DATA_WIDTH - TANH_W){TANH_LOW[TANH_W-1]}}, TANH_LOW};
                else if (s1_above_reg)
                    result_next = {{(DATA_WIDTH - TANH_W){1'b0}}, TANH_MAX};
                else
                    result_next = {{(DATA_WIDTH - TANH_W){tanh_val[TANH_W-1]}}, tanh_val};
            end
            default:
            begin
                result_next = s1_sample_reg;
            end
        endcase
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance_out)
        begin
            out_data_reg <= result_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_mode_reg  <= ACT_NONE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                act_mode_reg <= act_mode_t'(cfg_wr_data);
            end
            if (in_chan.ready)
            begin
                s1_valid_reg <= in_chan.valid;
            end
            if (advance_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // no transfer in while both stages are full and the output stalls
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_chan.ready) |-> !in_chan.ready)
        else $error("input taken while pipeline full");

    // an accepted sample occupies the lookup stage next cycle
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted sample lost before lookup stage");

    // a sample leaving the lookup stage lands in the output register
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance_out) |=> out_valid_reg)
        else $error("lookup result lost before output");

    // sigmoid results stay within 0 .. 1023
    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_mode_reg == ACT_SIGMOID))
            |-> (result_next <= DATA_WIDTH'(SIG_MAX)))
        else $error("sigmoid result out of range");

endmodule

>>> dv/activation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_checker: scoreboard for the fixed-point activation unit
// Watches both sample channels and the mode write port, computes the
// activated value of every accepted sample with its own Q62 exp arithmetic
// and compares each output transfer against the oldest predicted value.
// ----------------------------------------------------------------------------
module activation_checker #(
    parameter int DATA_WIDTH    = 32,
    parameter int TABLE_ENTRIES = 16384
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    fpau_in_if         in_chan,
    fpau_out_if        out_chan,
    output int         mismatches,
    output int         pending,
    output int         results_seen,
    output int         samples_seen,
    output int         lookups_seen,
    output int         saturated_seen
);
    import fpau_pkg::*;

    localparam int          HALF_RANGE = TABLE_ENTRIES / 2;
    localparam logic [63:0] UNIT_Q62   = 64'h4000_0000_0000_0000;

    act_mode_t                     mode_copy;
    logic signed [DATA_WIDTH-1:0]  activated_q[$];
    logic signed [DATA_WIDTH-1:0]  oldest;
    int                            error_total = 0;

    assign mismatches = error_total;

    // truncated q62 product of two values no larger than one
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[125:62];
    endfunction

    // exp(-steps/1024) in q62 via series for one step and square-and-multiply
    function automatic logic [63:0] decay_q62(input logic [19:0] steps);
        logic [63:0] term;
        logic [63:0] step_base;
        logic [63:0] acc;
        term      = UNIT_Q62;
        step_base = UNIT_Q62;
        acc       = UNIT_Q62;
        for (int n = 1; n <= 8; n++)
        begin
            term = (term >> 10) / 64'(n);
            if (n % 2 == 1)
            begin
                step_base = step_base - term;
            end
            else
            begin
                step_base = step_base + term;
            end
        end
        for (int i = 0; i < 20; i++)
        begin
            if (steps[i])
            begin
                acc = q62_product(acc, step_base);
            end
            step_base = q62_product(step_base, step_base);
        end
        return acc;
    endfunction

    // floor(1024 * num / den) by ten restoring steps, held below 1024
    function automatic logic [9:0] frac_quotient(input logic [63:0] num, input logic [63:0] den);
        logic [10:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = {1'b0, num};
        for (int i = 0; i < 10; i++)
        begin
            quo = quo << 1;
            rem = rem << 1;
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return (quo > 11'd1023) ? 10'd1023 : quo[9:0];
    endfunction

    // activated value of one sample under the given mode
    function automatic logic signed [DATA_WIDTH-1:0] activate(input act_mode_t mode,
                                                             input logic signed [DATA_WIDTH-1:0] x);
        logic [19:0]                  mag;
        logic [63:0]                  e;
        logic [9:0]                   quo;
        logic signed [DATA_WIDTH-1:0] res;
        mag = (x < 0) ? 20'(-x) : 20'(x);
        res = '0;
        case (mode)
            ACT_NONE:
            begin
                res = x;
            end
            ACT_RELU:
            begin
                res = (x < 0) ? '0 : x;
            end
            ACT_SIGMOID:
            begin
                if (x < -HALF_RANGE)
                begin
                    res = '0;
                end
                else if (x >= HALF_RANGE)
                begin
                    res = DATA_WIDTH'(1023);
                end
                else
                begin
                    e   = decay_q62(mag);
                    quo = (x < 0) ? frac_quotient(e, UNIT_Q62 + e)
                                  : frac_quotient(UNIT_Q62, UNIT_Q62 + e);
                    res = DATA_WIDTH'(quo);
                end
            end
            default:
            begin
                if (x < -HALF_RANGE)
                begin
                    res = -DATA_WIDTH'(1023);
                end
                else if (x >= HALF_RANGE)
                begin
                    res = DATA_WIDTH'(1023);
                end
                else
                begin
                    e   = decay_q62(20'(2 * mag));
                    quo = frac_quotient(UNIT_Q62 - e, UNIT_Q62 + e);
                    res = (x < 0) ? -DATA_WIDTH'(quo) : DATA_WIDTH'(quo);
                end
            end
        endcase
        return res;
    endfunction

    // one line per mismatch, counted
    task automatic report(input string what, input logic signed [DATA_WIDTH-1:0] got,
                          input logic signed [DATA_WIDTH-1:0] want);
        error_total++;
        $display("%0t ns: %s: got %0d, want %0d (mode %s)", $time, what, got, want,
                 mode_copy.name());
    endtask

    // compare output transfers, predict input transfers, follow mode writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_copy <= ACT_NONE;
            activated_q.delete();
            pending        <= 0;
            results_seen   <= 0;
            samples_seen   <= 0;
            lookups_seen   <= 0;
            saturated_seen <= 0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (activated_q.size() == 0)
                begin
                    report("result with no sample outstanding", out_chan.sample_out, '0);
                end
                else
                begin
                    oldest = activated_q.pop_front();
                    if (out_chan.sample_out !== oldest)
                    begin
                        report("sample_out differs", out_chan.sample_out, oldest);
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (in_chan.valid && in_chan.ready)
            begin
                activated_q.push_back(activate(mode_copy, in_chan.sample_in));
                samples_seen <= samples_seen + 1;
                if (mode_copy == ACT_SIGMOID || mode_copy == ACT_TANH)
                begin
                    if (in_chan.sample_in < -HALF_RANGE || in_chan.sample_in >= HALF_RANGE)
                    begin
                        saturated_seen <= saturated_seen + 1;
                    end
                    else
                    begin
                        lookups_seen <= lookups_seen + 1;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                mode_copy <= act_mode_t'(cfg_wr_data);
            end
            pending <= activated_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the fixed-point activation unit
// Runs a short directed set per mode, then random phases of samples in
// bursts under a random output stall pattern with one long hold-off, and
// reports the checker's result.
// ----------------------------------------------------------------------------
module testbench;

    import fpau_pkg::*;

    localparam int DATA_WIDTH    = 32;
    localparam int TABLE_ENTRIES = 16384;
    localparam int HALF_RANGE    = TABLE_ENTRIES / 2;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 178;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 600;
    localparam int QUIET_LIMIT   = 3000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;

    int mismatches;
    int pending;
    int results_seen;
    int samples_seen;
    int lookups_seen;
    int saturated_seen;
    int mode_writes = 0;

    fpau_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_chan ();
    fpau_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_chan ();

    // clock
    always #5 clk = ~clk;

    fixed_point_activation_unit #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (in_chan),
        .out_chan    (out_chan)
    );

    activation_checker #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_chan        (in_chan),
        .out_chan       (out_chan),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .samples_seen   (samples_seen),
        .lookups_seen   (lookups_seen),
        .saturated_seen (saturated_seen)
    );

    // offer one sample and hold it until the transfer
    task automatic offer_sample(input logic [DATA_WIDTH-1:0] value);
        in_chan.valid     <= 1'b1;
        in_chan.sample_in <= value;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
    endtask

    // drain the pipeline, then write the mode register
    task automatic set_mode(input act_mode_t mode);
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    // random sample, weighted toward the table range and its edges
    function automatic logic [DATA_WIDTH-1:0] random_sample();
        int                    pick;
        logic [DATA_WIDTH-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            v = $urandom_range(0, TABLE_ENTRIES - 1) - HALF_RANGE;
        end
        else if (pick < 60)
        begin
            v = HALF_RANGE - 4 + $urandom_range(0, 8);
            if ($urandom_range(0, 1) == 1)
            begin
                v = -v;
            end
        end
        else if (pick < 80)
        begin
            v = $urandom();
        end
        else if (pick < 90)
        begin
            v = $urandom_range(0, 127) - 64;
        end
        else
        begin
            v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
        end
        return v;
    endfunction

    // main stimulus and verdict
    initial
    begin
        int burst_left;
        int gap;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= ACT_NONE;
        in_chan.valid     <= 1'b0;
        in_chan.sample_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through keeps full-scale values
        offer_sample(32'h7FFF_FFFF);
        offer_sample(32'h8000_0000);
        offer_sample(32'h0000_0000);

        // relu around zero and at both ends
        set_mode(ACT_RELU);
        offer_sample(-32'sd1);
        offer_sample(32'sd0);
        offer_sample(32'sd1);
        offer_sample(32'h8000_0000);
        offer_sample(32'h7FFF_FFFF);

        // sigmoid at the table edges, saturation on both sides
        set_mode(ACT_SIGMOID);
        offer_sample(-32'sd8193);
        offer_sample(-32'sd8192);
        offer_sample(-32'sd1);
        offer_sample(32'sd0);
        offer_sample(32'sd1);
        offer_sample(32'sd8191);
        offer_sample(32'sd8192);
        offer_sample(32'h8000_0000);
        offer_sample(32'h7FFF_FFFF);

        // tanh at the table edges, saturation on both sides
        set_mode(ACT_TANH);
        offer_sample(-32'sd8193);
        offer_sample(-32'sd8192);
        offer_sample(-32'sd1);
        offer_sample(32'sd0);
        offer_sample(32'sd1);
        offer_sample(32'sd8191);
        offer_sample(32'sd8192);

        // random phases in bursts, each under its own mode
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
            begin
                set_mode(act_mode_t'(3 - p));
            end
            else
            begin
                set_mode(act_mode_t'($urandom_range(0, 3)));
            end
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                    begin
                        in_chan.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                offer_sample(random_sample());
                burst_left--;
            end
        end

        // drain and wait out the pipeline
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Run covered %0d samples over %0d mode writes: %0d table lookups, %0d saturated",
                 samples_seen, mode_writes, lookups_seen, saturated_seen);
        $display("%0d results checked under random output stalls and one %0d-cycle hold-off",
                 results_seen, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // output ready pattern with a single long hold-off
    initial
    begin
        int  seg_len;
        int  style;
        bit  held;
        held = 1'b0;
        out_chan.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 40);
            repeat (seg_len)
            begin
                case (style)
                    0:       out_chan.ready <= 1'b1;
                    1:       out_chan.ready <= ($urandom_range(0, 1) == 1);
                    2:       out_chan.ready <= ($urandom_range(0, 3) == 0);
                    default: out_chan.ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Watchdog: %0d cycles without a transfer, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fpau_pkg.sv
rtl/fpau_in_if.sv
rtl/fpau_out_if.sv
rtl/fixed_point_activation_unit.sv
dv/activation_checker.sv
dv/testbench.sv
